FILE: hdl/huf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_pkg
// Shared types and constants of the escape Huffman bit encoder.
// ----------------------------------------------------------------------------
package huf_pkg;

  localparam int SYM_W        = 8;
  localparam int CODE_W       = 24;
  localparam int LEN_W        = 5;
  localparam int WORD_W       = 32;
  localparam int VB_W         = 6;
  localparam int TABLE_DEPTH  = 256;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd24;
  localparam logic [VB_W-1:0]  RAW_BITS     = 6'd8;
  localparam logic [SYM_W-1:0] ESC_INDEX    = 8'd128;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic              present;
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic              last;
    logic [VB_W-1:0]   valid_bits;
    logic [WORD_W-1:0] packed_word;
  } word_t;

  typedef struct packed {
    logic [1:0] count;
    word_t      first;
    word_t      second;
  } push_t;

endpackage

FILE: hdl/huf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module huf_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/huf_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_table
// Code table: length and code bits in RAM, present flags in flops, and a
// shadow copy of the escape entry so that one RAM read serves each sample.
// ----------------------------------------------------------------------------
module huf_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [huf_pkg::SYM_W-1:0]   wr_sym_i,
  input  logic [huf_pkg::CODE_W-1:0]  wr_code_i,
  input  logic [huf_pkg::LEN_W-1:0]   wr_len_i,
  input  logic                        wr_present_i,
  input  logic                        rd_en_i,
  input  logic [huf_pkg::SYM_W-1:0]   rd_sym_i,
  output huf_pkg::entry_t             rd_entry_o,
  output huf_pkg::entry_t             esc_entry_o
);

  localparam int RAM_W = huf_pkg::LEN_W + huf_pkg::CODE_W;

  logic [huf_pkg::TABLE_DEPTH-1:0] pres_q;
  logic                            pres_rd_q;
  huf_pkg::entry_t                 esc_q;
  logic [huf_pkg::LEN_W-1:0]       len_sat;
  logic [huf_pkg::CODE_W:0]        code_mask;
  logic [huf_pkg::CODE_W-1:0]      code_trim;
  logic [RAM_W-1:0]                ram_rdata;

  // Overlong codes saturate; bits above the stored length are dropped.
  always_comb begin
    len_sat   = (wr_len_i > huf_pkg::MAX_CODE_LEN) ? huf_pkg::MAX_CODE_LEN : wr_len_i;
    code_mask = (25'd1 << len_sat) - 25'd1;
    code_trim = wr_code_i & code_mask[huf_pkg::CODE_W-1:0];
  end

  huf_ram #(
    .WIDTH(RAM_W),
    .DEPTH(huf_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_sym_i),
    .wdata_i({len_sat, code_trim}),
    .re_i   (rd_en_i),
    .raddr_i(rd_sym_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q    <= '0;
      pres_rd_q <= 1'b0;
      esc_q     <= '0;
    end else begin
      if (wr_en_i) begin
        pres_q[wr_sym_i] <= wr_present_i;
        if (wr_sym_i == huf_pkg::ESC_INDEX) begin
          esc_q.present <= wr_present_i;
          esc_q.length  <= len_sat;
          esc_q.code    <= code_trim;
        end
      end
      if (rd_en_i) begin
        pres_rd_q <= pres_q[rd_sym_i];
      end
    end
  end

  always_comb begin
    rd_entry_o.present = pres_rd_q;
    rd_entry_o.length  = ram_rdata[RAM_W-1:huf_pkg::CODE_W];
    rd_entry_o.code    = ram_rdata[huf_pkg::CODE_W-1:0];
  end

  assign esc_entry_o = esc_q;

endmodule

FILE: hdl/huf_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_packer
// Appends one sample's bits to the left-aligned accumulator, cuts full words
// and the flush word at block end.
// ----------------------------------------------------------------------------
module huf_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [huf_pkg::SYM_W-1:0]  sym_i,
  input  logic                       block_end_i,
  input  huf_pkg::entry_t            entry_i,
  input  huf_pkg::entry_t            esc_i,
  output huf_pkg::push_t             push_o
);

  logic [huf_pkg::WORD_W-1:0]   acc_q, acc_d;
  logic [huf_pkg::LEN_W-1:0]    cnt_q, cnt_d;
  logic [huf_pkg::VB_W-1:0]     n_bits;
  logic [huf_pkg::WORD_W-1:0]   value;
  logic [huf_pkg::VB_W-1:0]     total;
  logic [6:0]                   shamt;
  logic [2*huf_pkg::WORD_W-1:0] merged;
  logic                         full;
  logic [huf_pkg::LEN_W-1:0]    rem;
  logic [huf_pkg::WORD_W-1:0]   acc_after;
  logic                         flush;

  always_comb begin
    if (entry_i.present) begin
      n_bits = {1'b0, entry_i.length};
      value  = {8'd0, entry_i.code};
    end else if (esc_i.present) begin
      n_bits = {1'b0, esc_i.length} + huf_pkg::RAW_BITS;
      value  = {esc_i.code, sym_i};
    end else begin
      n_bits = huf_pkg::RAW_BITS;
      value  = {24'd0, sym_i};
    end

    // Pending bits sit at the top of acc_q; the new bits land right below them.
    total     = {1'b0, cnt_q} + n_bits;
    shamt     = 7'd64 - {1'b0, total};
    merged    = {acc_q, 32'd0} | ({32'd0, value} << shamt);
    full      = total[5];
    rem       = total[4:0];
    acc_after = full ? merged[31:0] : merged[63:32];
    flush     = block_end_i && (rem != '0);

    push_o.first.packed_word  = full ? merged[63:32] : acc_after;
    push_o.first.valid_bits   = full ? 6'd32 : {1'b0, rem};
    push_o.first.last         = block_end_i;
    push_o.second.packed_word = acc_after;
    push_o.second.valid_bits  = {1'b0, rem};
    push_o.second.last        = 1'b1;
    if (!fire_i) begin
      push_o.count = 2'd0;
    end else begin
      push_o.count = {1'b0, full} + {1'b0, flush};
    end
    // A full word is last only when nothing is left to flush after it.
    if (full && flush) begin
      push_o.first.last = 1'b0;
    end

    acc_d = acc_q;
    cnt_d = cnt_q;
    if (fire_i) begin
      acc_d = block_end_i ? '0 : acc_after;
      cnt_d = block_end_i ? '0 : rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/huf_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_out_fifo
// Small result queue: takes up to two words per cycle, hands one out on ready.
// ----------------------------------------------------------------------------
module huf_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  huf_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output huf_pkg::word_t out_word_o
);

  huf_pkg::word_t mem_q [huf_pkg::FIFO_DEPTH];
  logic [1:0]     wr_ptr_q, wr_ptr_d;
  logic [1:0]     rd_ptr_q, rd_ptr_d;
  logic [2:0]     cnt_q, cnt_d;
  logic           pop;
  logic [1:0]     wr_ptr_nx;

  always_comb begin
    pop       = (cnt_q != 3'd0) && out_ready_i;
    wr_ptr_nx = wr_ptr_q + 2'd1;
    wr_ptr_d  = wr_ptr_q + push_i.count;
    rd_ptr_d  = rd_ptr_q + {1'b0, pop};
    cnt_d     = cnt_q + {1'b0, push_i.count} - {2'd0, pop};
  end

  // Room for a worst-case item of two words, ignoring a pop in the same cycle.
  assign room_o      = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hdl/huffman_escape_bit_encoder_top.sv
`timescale 1ns / 1ps
// A sample waits in the sample register while its table entry is read; its words then go
// into the result queue, and a full queue holds the sample back. Throughput: one item per
// cycle while the queue has room; the single table RAM read port serves each sample.
// A sample yields at most two words; the output gives one per cycle while tready is high.
// Reset: all table entries absent, accumulator empty, result queue empty.
// Table RAM contents are not cleared; per-entry present flags gate them.
// ----------------------------------------------------------------------------
// huffman_escape_bit_encoder_top
// Static Huffman encoder with escape code, packing bits MSB first into
// 32-bit words.
// ----------------------------------------------------------------------------
module huffman_escape_bit_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // symbol[7:0], code_value[31:8], code_length[36:32], entry_present[37], zero pad
  input  logic [39:0] s_axis_tdata,
  // func
  input  logic        s_axis_tuser,
  // block_end
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // packed_word[31:0], valid_bits[37:32], zero pad
  output logic [39:0] m_axis_tdata,
  // last
  output logic        m_axis_tlast
);

  logic                       accept;
  logic                       accept_wr;
  logic                       accept_smp;
  logic                       room;
  logic                       fire;
  logic                       smp_vld_q, smp_vld_d;
  logic [huf_pkg::SYM_W-1:0]  smp_sym_q;
  logic                       smp_end_q;
  huf_pkg::entry_t            rd_entry;
  huf_pkg::entry_t            esc_entry;
  huf_pkg::push_t             push;
  huf_pkg::word_t             out_word;

  assign s_axis_tready = !smp_vld_q || room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign accept_wr     = accept && (s_axis_tuser == huf_pkg::FUNC_WRITE);
  assign accept_smp    = accept && (s_axis_tuser == huf_pkg::FUNC_SAMPLE);
  assign fire          = smp_vld_q && room;

  always_comb begin
    smp_vld_d = smp_vld_q;
    if (accept_smp) begin
      smp_vld_d = 1'b1;
    end else if (fire) begin
      smp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else begin
      smp_vld_q <= smp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_smp) begin
      smp_sym_q <= s_axis_tdata[7:0];
      smp_end_q <= s_axis_tlast;
    end
  end

  huf_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept_wr),
    .wr_sym_i    (s_axis_tdata[7:0]),
    .wr_code_i   (s_axis_tdata[31:8]),
    .wr_len_i    (s_axis_tdata[36:32]),
    .wr_present_i(s_axis_tdata[37]),
    .rd_en_i     (accept_smp),
    .rd_sym_i    (s_axis_tdata[7:0]),
    .rd_entry_o  (rd_entry),
    .esc_entry_o (esc_entry)
  );

  huf_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .sym_i      (smp_sym_q),
    .block_end_i(smp_end_q),
    .entry_i    (rd_entry),
    .esc_i      (esc_entry),
    .push_o     (push)
  );

  huf_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_word_o (out_word)
  );

  assign m_axis_tdata = {2'b00, out_word.valid_bits, out_word.packed_word};
  assign m_axis_tlast = out_word.last;

endmodule

FILE: dv/huf_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_word_checker
// Watches both streams of the escape Huffman encoder. It keeps its own copy
// of the code table and the bit accumulator, works out the packed words of
// every accepted sample, and compares each word that leaves the block with
// the oldest word still expected.
// ----------------------------------------------------------------------------
module huf_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // symbol[7:0], code_value[31:8], code_length[36:32], entry_present[37], zero pad
  input  logic [39:0] s_axis_tdata_i,
  // func
  input  logic        s_axis_tuser_i,
  // block_end
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // packed_word[31:0], valid_bits[37:32], zero pad
  input  logic [39:0] m_axis_tdata_i,
  // last
  input  logic        m_axis_tlast_i,
  output int          err_count_o,
  output int          words_pending_o
);

  import huf_pkg::*;

  entry_t            code_book [TABLE_DEPTH];
  logic [WORD_W-1:0] pend_bits;
  int                pend_cnt;
  word_t             words_exp [$];

  task automatic queue_word(input word_t w);
    words_exp.insert(words_exp.size(), w);
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] idx, input logic [CODE_W-1:0] cval,
                            input logic [LEN_W-1:0] clen, input logic pres);
    logic [LEN_W-1:0] len;
    len = (clen > MAX_CODE_LEN) ? MAX_CODE_LEN : clen;
    code_book[idx].present = pres;
    code_book[idx].length  = len;
    code_book[idx].code    = cval & CODE_W'((64'd1 << len) - 64'd1);
  endtask

  // Appends n code bits and queues every word that fills up.
  task automatic append_bits(input logic [CODE_W-1:0] value, input int n, inout int made);
    logic [63:0] acc;
    int          cnt;
    word_t       w;
    if (n != 0) begin
      acc = ({32'd0, pend_bits} << n) | ({40'd0, value} & ((64'd1 << n) - 64'd1));
      cnt = pend_cnt + n;
      while (cnt >= WORD_W) begin
        w.packed_word = WORD_W'(acc >> (cnt - WORD_W));
        w.valid_bits  = VB_W'(WORD_W);
        w.last        = 1'b0;
        queue_word(w);
        made++;
        cnt -= WORD_W;
        acc &= (64'd1 << cnt) - 64'd1;
      end
      pend_bits = WORD_W'(acc);
      pend_cnt  = cnt;
    end
  endtask

  task automatic encode_sample(input logic [SYM_W-1:0] sym, input logic blk_end);
    int    made;
    word_t w;
    made = 0;
    if (code_book[sym].present) begin
      append_bits(code_book[sym].code, int'(code_book[sym].length), made);
    end else begin
      if (code_book[ESC_INDEX].present) begin
        append_bits(code_book[ESC_INDEX].code, int'(code_book[ESC_INDEX].length), made);
      end
      append_bits(CODE_W'(sym), int'(RAW_BITS), made);
    end
    if (blk_end) begin
      if (pend_cnt > 0) begin
        w.packed_word = pend_bits << (WORD_W - pend_cnt);
        w.valid_bits  = VB_W'(pend_cnt);
        w.last        = 1'b1;
        queue_word(w);
        pend_bits = '0;
        pend_cnt  = 0;
      end else if (made > 0) begin
        // Nothing pending: the full word this sample just made closes the block.
        w = words_exp.pop_back();
        w.last = 1'b1;
        queue_word(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_t got;
    word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        code_book[i] = '0;
      end
      pend_bits = '0;
      pend_cnt  = 0;
      words_exp.delete();
      err_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == FUNC_WRITE) begin
          load_entry(s_axis_tdata_i[7:0], s_axis_tdata_i[31:8], s_axis_tdata_i[36:32],
                     s_axis_tdata_i[37]);
        end else begin
          encode_sample(s_axis_tdata_i[7:0], s_axis_tlast_i);
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.packed_word = m_axis_tdata_i[31:0];
        got.valid_bits  = m_axis_tdata_i[37:32];
        got.last        = m_axis_tlast_i;
        if (words_exp.size() == 0) begin
          $display("%0t: word %08h bits %0d last %0d arrived with none expected",
                   $time, got.packed_word, got.valid_bits, got.last);
          err_count_o++;
        end else begin
          want = words_exp.pop_front();
          if (got.packed_word !== want.packed_word) begin
            $display("%0t: packed_word expected %08h actual %08h",
                     $time, want.packed_word, got.packed_word);
            err_count_o++;
          end
          if (got.valid_bits !== want.valid_bits) begin
            $display("%0t: valid_bits expected %0d actual %0d",
                     $time, want.valid_bits, got.valid_bits);
            err_count_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            err_count_o++;
          end
        end
      end
    end
    words_pending_o = words_exp.size();
  end

endmodule

FILE: dv/huffman_escape_bit_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_escape_bit_encoder_top_test
// Drives table writes and samples into the escape Huffman encoder: a directed
// run through the corner cases, then random phases of table loads followed by
// sample streams, with random gaps on the input and stalls on the output.
// A checker beside the block predicts and compares every packed word.
// ----------------------------------------------------------------------------
module huffman_escape_bit_encoder_top_test;

  import huf_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int         err_count;
  int         words_pending;
  bit         tx_steady = 1'b1;
  bit         rx_steady = 1'b1;
  int         rx_hold   = 0;
  logic [7:0] known_syms [16];
  int         known_wr  = 0;
  int         item_cnt  = 0;

  huffman_escape_bit_encoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  huf_word_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .err_count_o     (err_count),
    .words_pending_o (words_pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Output stalls: mostly short, now and then long, none in steady phases.
  always @(negedge clk_i) begin
    int roll;
    if (rx_hold == 0 && !rx_steady) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        rx_hold = $urandom_range(1, 3);
      end else if (roll < 23) begin
        rx_hold = $urandom_range(10, 40);
      end
    end
    if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_item(input logic func, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] cval, input logic [LEN_W-1:0] clen,
                           input logic pres, input logic blk_end);
    int gap;
    int roll;
    gap  = 0;
    roll = $urandom_range(0, 99);
    if (!tx_steady) begin
      if (roll >= 95) begin
        gap = $urandom_range(8, 40);
      end else if (roll >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tlast  = blk_end;
    s_axis_tdata  = {2'b00, pres, clen, cval, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    item_cnt++;
  endtask

  // Holds the input back until every expected word has left the block.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_write();
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] clen;
    int               roll;
    roll = $urandom_range(0, 99);
    sym  = (roll < 10) ? ESC_INDEX : SYM_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      clen = '0;
    end else if (roll < 20) begin
      clen = MAX_CODE_LEN;
    end else if (roll < 30) begin
      clen = LEN_W'($urandom_range(25, 31));
    end else begin
      clen = LEN_W'($urandom_range(1, 24));
    end
    send_item(FUNC_WRITE, sym, CODE_W'($urandom), clen, $urandom_range(0, 99) < 85,
              1'($urandom));
    known_syms[known_wr] = sym;
    known_wr = (known_wr + 1) % 16;
  endtask

  task automatic random_sample(input logic blk_end);
    logic [SYM_W-1:0] sym;
    if ($urandom_range(0, 1)) begin
      sym = known_syms[$urandom_range(0, 15)];
    end else begin
      sym = SYM_W'($urandom_range(0, 255));
    end
    send_item(FUNC_SAMPLE, sym, CODE_W'($urandom), LEN_W'($urandom), 1'($urandom), blk_end);
  endtask

  initial begin
    int phase;
    int n_smp;
    for (int i = 0; i < 16; i++) begin
      known_syms[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Samples against an empty table: no escape code, raw bits only.
    send_item(FUNC_SAMPLE, 8'h00, 24'h000000, 5'd0,  1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'hFF, 24'hFFFFFF, 5'd31, 1'b1, 1'b1);
    // Table loads: escape entry with block end set, longest code, zero length,
    // overlong length, an entry written as absent, and a 16-bit code.
    send_item(FUNC_WRITE, ESC_INDEX, 24'h000015, 5'd5,  1'b1, 1'b1);
    send_item(FUNC_WRITE, 8'hFF, 24'hFFFFFF, 5'd24, 1'b1, 1'b0);
    send_item(FUNC_WRITE, 8'h00, 24'h000003, 5'd0,  1'b1, 1'b0);
    send_item(FUNC_WRITE, 8'h55, 24'hABCDEF, 5'd31, 1'b1, 1'b0);
    send_item(FUNC_WRITE, 8'hAA, 24'h00007F, 5'd7,  1'b0, 1'b0);
    send_item(FUNC_WRITE, 8'h10, 24'h00A5A5, 5'd16, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, 8'hFF, 24'h0, 5'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'h55, 24'h0, 5'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'hAA, 24'h0, 5'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, ESC_INDEX, 24'h0, 5'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'h00, 24'h0, 5'd0, 1'b0, 1'b1);
    // Block end with nothing pending and nothing sent gives no word at all.
    send_item(FUNC_SAMPLE, 8'h00, 24'h0, 5'd0, 1'b0, 1'b1);
    // Two 16-bit codes fill one word exactly, so that word carries last.
    send_item(FUNC_SAMPLE, 8'h10, 24'h0, 5'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'h10, 24'h0, 5'd0, 1'b0, 1'b1);
    send_item(FUNC_WRITE, ESC_INDEX, 24'h000015, 5'd5, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 8'h33, 24'h0, 5'd0, 1'b0, 1'b1);
    send_item(FUNC_WRITE, ESC_INDEX, 24'hFFFFFF, 5'd0, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, 8'h01, 24'h0, 5'd0, 1'b0, 1'b1);
    send_item(FUNC_WRITE, 8'h01, 24'h000001, 5'd1, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, 8'h01, 24'h0, 5'd0, 1'b0, 1'b1);
    drain();

    phase = 0;
    while (item_cnt < 550) begin
      phase++;
      tx_steady = (phase % 4 == 1);
      rx_steady = (phase % 4 == 2);
      repeat ($urandom_range(4, 20)) random_write();
      n_smp = $urandom_range(40, 90);
      for (int k = 0; k < n_smp && item_cnt < 550; k++) begin
        // A few table writes land in the middle of the sample stream.
        if ($urandom_range(0, 99) < 5) begin
          random_write();
        end else begin
          random_sample(k == n_smp - 1 || $urandom_range(0, 11) == 0);
        end
      end
      if (phase % 2 == 0) begin
        drain();
      end
    end

    tx_steady = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && words_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/huf_pkg.sv
hdl/huf_ram.sv
hdl/huf_table.sv
hdl/huf_packer.sv
hdl/huf_out_fifo.sv
hdl/huffman_escape_bit_encoder_top.sv
dv/huf_word_checker.sv
dv/huffman_escape_bit_encoder_top_test.sv
